### sv/tie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tie_pkg: shared types and opcode constants for the Thumb instruction encoder
// Holds the request kinds, the field widths and the base opcodes of every
// 16-bit and 32-bit encoding that the encoder produces.
// ----------------------------------------------------------------------------
package tie_pkg;

	// Field widths of one request beat and one result beat.
	localparam int ActionW = 5;
	localparam int RegW    = 4;
	localparam int LoRegW  = 3;
	localparam int ImmW    = 8;
	localparam int CondW   = 4;
	localparam int AluOpW  = 4;
	localparam int OffsetW = 25;
	localparam int MaskW   = 16;
	localparam int WordW   = 32;
	localparam int HalfW   = 16;

	// Request kinds.
	typedef enum logic [ActionW-1:0] {
		ACT_MOV_IMM  = 5'd0,
		ACT_MOV_REG  = 5'd1,
		ACT_ADD_REG  = 5'd2,
		ACT_ADD_IMM3 = 5'd3,
		ACT_ADD_IMM8 = 5'd4,
		ACT_SUB_REG  = 5'd5,
		ACT_SUB_IMM3 = 5'd6,
		ACT_SUB_IMM8 = 5'd7,
		ACT_CMP_IMM  = 5'd8,
		ACT_LDR_SP   = 5'd9,
		ACT_STR_SP   = 5'd10,
		ACT_LDR_IMM  = 5'd11,
		ACT_STR_IMM  = 5'd12,
		ACT_LDRB     = 5'd13,
		ACT_STRB     = 5'd14,
		ACT_PUSH     = 5'd15,
		ACT_POP      = 5'd16,
		ACT_B        = 5'd17,
		ACT_BL       = 5'd18,
		ACT_BX       = 5'd19,
		ACT_BCOND    = 5'd20,
		ACT_ALU      = 5'd21,
		ACT_ADD_SP   = 5'd22,
		ACT_SUB_SP   = 5'd23,
		ACT_SVC      = 5'd24,
		ACT_NOP      = 5'd25
	} action_t;

	// Highest condition code that a conditional branch accepts (LE).
	localparam logic [CondW-1:0] COND_LAST = 4'd13;

	// Base opcodes.
	localparam logic [HalfW-1:0] OP_MOV_IMM  = 16'h2000;
	localparam logic [HalfW-1:0] OP_CMP_IMM  = 16'h2800;
	localparam logic [HalfW-1:0] OP_ADD_IMM8 = 16'h3000;
	localparam logic [HalfW-1:0] OP_SUB_IMM8 = 16'h3800;
	localparam logic [HalfW-1:0] OP_ADD_REG  = 16'h1800;
	localparam logic [HalfW-1:0] OP_SUB_REG  = 16'h1A00;
	localparam logic [HalfW-1:0] OP_ADD_IMM3 = 16'h1C00;
	localparam logic [HalfW-1:0] OP_SUB_IMM3 = 16'h1E00;
	localparam logic [HalfW-1:0] OP_ALU      = 16'h4000;
	localparam logic [HalfW-1:0] OP_MOV_HI   = 16'h4600;
	localparam logic [HalfW-1:0] OP_BX       = 16'h4700;
	localparam logic [HalfW-1:0] OP_STR_IMM  = 16'h6000;
	localparam logic [HalfW-1:0] OP_LDR_IMM  = 16'h6800;
	localparam logic [HalfW-1:0] OP_STRB     = 16'h7000;
	localparam logic [HalfW-1:0] OP_LDRB     = 16'h7800;
	localparam logic [HalfW-1:0] OP_STR_SP   = 16'h9000;
	localparam logic [HalfW-1:0] OP_LDR_SP   = 16'h9800;
	localparam logic [HalfW-1:0] OP_ADD_SP   = 16'hB000;
	localparam logic [HalfW-1:0] OP_SUB_SP   = 16'hB080;
	localparam logic [HalfW-1:0] OP_PUSH     = 16'hB400;
	localparam logic [HalfW-1:0] OP_POP      = 16'hBC00;
	localparam logic [HalfW-1:0] OP_NOP      = 16'hBF00;
	localparam logic [HalfW-1:0] OP_BCOND    = 16'hD000;
	localparam logic [HalfW-1:0] OP_SVC      = 16'hDF00;
	localparam logic [HalfW-1:0] OP_B        = 16'hE000;
	localparam logic [HalfW-1:0] OP_BL_HI    = 16'hF000;
	localparam logic [HalfW-1:0] OP_BL_LO    = 16'hD000;

endpackage

### sv/thumb_instruction_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb_instruction_encoder_top: Thumb instruction encoder
// Turns one instruction request into its Thumb machine encoding. 16-bit kinds
// come back in the low half of instr_word; BL returns both halfwords, the
// first one in the upper half.
//
//   Channel   Handshake                 Payload
//   request   start, busy (always low)  action .. register_mask
//   result    done (one-cycle strobe)   instr_word, is_wide
//
// A request beat is taken at every edge with start high; busy never rises.
// The result strobe follows from the request edge through the input register
// and then the result register, which captures the encoding.
// One beat per cycle is sustained, since each stage holds one request.
// Reset clears both stage valid flags; payload registers are not reset.
// The receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module thumb_instruction_encoder_top
	import tie_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ActionW-1:0]        action,
	input  logic [RegW-1:0]           dest_reg,
	input  logic [LoRegW-1:0]         base_reg,
	input  logic [RegW-1:0]           src_reg,
	input  logic [ImmW-1:0]           immediate,
	input  logic [CondW-1:0]          cond_code,
	input  logic [AluOpW-1:0]         alu_operation,
	input  logic signed [OffsetW-1:0] branch_offset,
	input  logic [MaskW-1:0]          register_mask,
	output logic                      done,
	output logic [WordW-1:0]          instr_word,
	output logic                      is_wide
);

	logic                 valid_s1;
	logic [ActionW-1:0]   action_s1;
	logic [RegW-1:0]      rd_s1;
	logic [LoRegW-1:0]    rn_s1;
	logic [RegW-1:0]      rm_s1;
	logic [ImmW-1:0]      imm_s1;
	logic [CondW-1:0]     cond_s1;
	logic [AluOpW-1:0]    op_s1;
	logic [OffsetW-1:0]   off_s1;
	logic [MaskW-1:0]     mask_s1;

	logic                 valid_s2;
	logic [WordW-1:0]     word_s2;
	logic                 wide_s2;

	logic [WordW-1:0]     word_d;
	logic                 wide_d;
	logic [HalfW-1:0]     half_d;
	logic [LoRegW-1:0]    rd_lo;
	logic [LoRegW-1:0]    rm_lo;
	logic                 bl_s;
	logic                 bl_j1;
	logic                 bl_j2;

	// Every request is taken at once.
	assign busy = 1'b0;

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	// Input register payload, loaded with each request beat.
	always_ff @(posedge clk) begin
		if (start) begin
			action_s1 <= action;
			rd_s1     <= dest_reg;
			rn_s1     <= base_reg;
			rm_s1     <= src_reg;
			imm_s1    <= immediate;
			cond_s1   <= cond_code;
			op_s1     <= alu_operation;
			off_s1    <= branch_offset;
			mask_s1   <= register_mask;
		end
	end

	assign rd_lo = rd_s1[LoRegW-1:0];
	assign rm_lo = rm_s1[LoRegW-1:0];

	// BL sign and J bits from offset bits 24, 23 and 22.
	assign bl_s  = off_s1[24];
	assign bl_j1 = ~(off_s1[23] ^ bl_s);
	assign bl_j2 = ~(off_s1[22] ^ bl_s);

	// Field packing per kind; unknown kinds and Bcond codes above LE give NOP.
	always_comb begin
		half_d = OP_NOP;
		wide_d = 1'b0;
		word_d = '0;
		case (action_t'(action_s1))
			ACT_MOV_IMM:  half_d = OP_MOV_IMM | {5'd0, rd_lo, imm_s1};
			ACT_MOV_REG: begin
				if (!rd_s1[3] && !rm_s1[3]) begin
					half_d = OP_ADD_IMM3 | {10'd0, rm_lo, rd_lo};
				end else begin
					half_d = OP_MOV_HI | {8'd0, rd_s1[3], rm_s1, rd_lo};
				end
			end
			ACT_ADD_REG:  half_d = OP_ADD_REG | {7'd0, rm_lo, rn_s1, rd_lo};
			ACT_ADD_IMM3: half_d = OP_ADD_IMM3 | {7'd0, imm_s1[2:0], rn_s1, rd_lo};
			ACT_ADD_IMM8: half_d = OP_ADD_IMM8 | {5'd0, rd_lo, imm_s1};
			ACT_SUB_REG:  half_d = OP_SUB_REG | {7'd0, rm_lo, rn_s1, rd_lo};
			ACT_SUB_IMM3: half_d = OP_SUB_IMM3 | {7'd0, imm_s1[2:0], rn_s1, rd_lo};
			ACT_SUB_IMM8: half_d = OP_SUB_IMM8 | {5'd0, rd_lo, imm_s1};
			ACT_CMP_IMM:  half_d = OP_CMP_IMM | {5'd0, rd_lo, imm_s1};
			ACT_LDR_SP:   half_d = OP_LDR_SP | {5'd0, rd_lo, imm_s1};
			ACT_STR_SP:   half_d = OP_STR_SP | {5'd0, rd_lo, imm_s1};
			ACT_LDR_IMM:  half_d = OP_LDR_IMM | {5'd0, imm_s1[4:0], rn_s1, rd_lo};
			ACT_STR_IMM:  half_d = OP_STR_IMM | {5'd0, imm_s1[4:0], rn_s1, rd_lo};
			ACT_LDRB:     half_d = OP_LDRB | {5'd0, imm_s1[4:0], rn_s1, rd_lo};
			ACT_STRB:     half_d = OP_STRB | {5'd0, imm_s1[4:0], rn_s1, rd_lo};
			ACT_PUSH:     half_d = OP_PUSH | {7'd0, mask_s1[14], mask_s1[7:0]};
			ACT_POP:      half_d = OP_POP | {7'd0, mask_s1[15], mask_s1[7:0]};
			ACT_B:        half_d = OP_B | {5'd0, off_s1[11:1]};
			ACT_BL:       wide_d = 1'b1;
			ACT_BX:       half_d = OP_BX | {9'd0, rm_s1, 3'd0};
			ACT_BCOND: begin
				if (cond_s1 <= COND_LAST) begin
					half_d = OP_BCOND | {4'd0, cond_s1, off_s1[8:1]};
				end
			end
			ACT_ALU:      half_d = OP_ALU | {6'd0, op_s1, rm_lo, rd_lo};
			ACT_ADD_SP:   half_d = OP_ADD_SP | {9'd0, imm_s1[6:0]};
			ACT_SUB_SP:   half_d = OP_SUB_SP | {9'd0, imm_s1[6:0]};
			ACT_SVC:      half_d = OP_SVC | {8'd0, imm_s1};
			ACT_NOP:      half_d = OP_NOP;
			default:      half_d = OP_NOP;
		endcase
		if (wide_d) begin
			word_d = {OP_BL_HI | {5'd0, bl_s, off_s1[21:12]},
			          OP_BL_LO | {2'd0, bl_j1, 1'b0, bl_j2, off_s1[11:1]}};
		end else begin
			word_d = {{HalfW{1'b0}}, half_d};
		end
	end

	// Result register valid flag, which is the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			word_s2 <= word_d;
			wide_s2 <= wide_d;
		end
	end

	assign done       = valid_s2;
	assign instr_word = word_s2;
	assign is_wide    = wide_s2;

endmodule
